@@ rtl/core/sfs_pkg.sv @@
`default_nettype none

package sfs_pkg;

    // Frame numbers are 10 bits wide on the stream and in all state.
    localparam int FrameW   = 10;
    localparam int DelayW   = 16;
    localparam int PerRowW  = 8;
    localparam int PixelW   = 12;
    localparam int TexXW    = 20;
    localparam int TexYW    = 22;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_DRAW     = 2'd1;
    localparam logic [1:0] OP_SET_LOOP = 2'd2;

    // Register indexes, as selected by paddr[3:2].
    localparam logic [1:0] REG_FRAME_DELAY    = 2'd0;
    localparam logic [1:0] REG_FRAMES_PER_ROW = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_COL,
        S_MUL_ROW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [FrameW-1:0]  quotient;
        logic [PerRowW-1:0] remainder;
    } div_result_t;

endpackage

`default_nettype wire

@@ rtl/core/sfs_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sfs_divider import sfs_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [FrameW-1:0]   dividend,
    input  wire logic [PerRowW-1:0]  divisor,
    output logic                     busy,
    output logic                     done,
    output div_result_t              result
);

    localparam int CountW = $clog2(FrameW + 1);

    logic [CountW-1:0]  count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [FrameW-1:0]  quo_reg, quo_next;
    logic [PerRowW-1:0] rem_reg, rem_next;
    logic [PerRowW-1:0] div_reg, div_next;
    logic [PerRowW:0]   shifted;
    logic [PerRowW:0]   diff;
    logic               fits;

    assign shifted = {rem_reg, quo_reg[FrameW-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start) begin
            count_next = CountW'(FrameW);
            busy_next  = 1'b1;
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (busy_reg) begin
            quo_next   = {quo_reg[FrameW-2:0], fits};
            rem_next   = fits ? diff[PerRowW-1:0] : shifted[PerRowW-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == CountW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy             = busy_reg;
    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/sprite_frame_sequencer.sv @@
`default_nettype none

// Sprite-sheet animation stepper. Input beats carry a kind in s_tuser: a tick adds one
// millisecond to a saturating elapsed counter, a set-loop loads the loop flag and, unless
// the range is unchanged, a new frame range, direction and start frame, and a draw may
// step the current frame and then returns one result beat with the frame number and its
// texture position in the sheet. Ticks, set-loops and unknown kinds give no result. When
// frames_per_row exceeds one, a draw goes through these steps in order: accept the beat
// and step the frame; let the bit-serial divider split the frame into row and column,
// producing ten quotient bits, and wait until the sequencer sees it finish; use the single
// shared 10x12 multiplier for the column and then the row; hand the result to the
// output register. With frames_per_row of zero or one a draw skips the divider and the
// multiplier. The hand-off waits while the output register still holds an earlier
// result that the sink has not taken. The block accepts no new beat while a draw is in
// flight, but a finished result may wait in the output register while the next beat is
// taken. Configuration is through a small APB port with four registers, read as 32-bit
// words, at byte offsets 0, 4, 8 and 12, which the user must write only while the block
// is idle; the block itself does not enforce this.
module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // loop_start[9:0], loop_stop[19:10], loop_enable[20]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // frame_index[9:0], texture_x[29:10], texture_y[51:30]
    output logic [0:0]       m_tuser,   // rect_set[0]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Frames saturate at the lower of MAX_FRAMES-1 and the largest 10-bit frame number.
    localparam int CapInt = (MAX_FRAMES - 1 > 1023) ? 1023 : MAX_FRAMES - 1;
    localparam logic [FrameW-1:0] FrameCap = FrameW'(CapInt);

    // Configuration registers.
    logic [DelayW-1:0]  frame_delay_reg;
    logic [PerRowW-1:0] frames_per_row_reg;
    logic [PixelW-1:0]  frame_width_reg;
    logic [PixelW-1:0]  frame_height_reg;

    // Animation state.
    logic [DelayW-1:0]  elapsed_reg;
    logic [FrameW-1:0]  frame_reg;
    logic [FrameW-1:0]  range_low_reg;
    logic [FrameW-1:0]  range_high_reg;
    logic               down_reg;
    logic               looping_reg;

    // Sequencer and working registers.
    state_t             state_reg, state_next;
    logic [TexXW-1:0]   tex_x_reg;
    logic [TexYW-1:0]   tex_y_reg;
    logic               rect_reg;

    // Output register.
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic               m_rect_reg;

    // Sequencer outputs.
    logic               accept;
    logic               load_out;
    logic               mul_row;

    // Decoded input beat.
    logic [1:0]         opcode;
    logic [FrameW-1:0]  in_start;
    logic [FrameW-1:0]  in_stop;
    logic               in_enable;

    // Frame step logic.
    logic               at_end;
    logic               do_advance;
    logic [FrameW:0]    step_val;
    logic [FrameW-1:0]  stepped;
    logic [FrameW-1:0]  start_sat;
    logic [FrameW-1:0]  draw_frame;
    logic               wide_sheet;
    logic               same_range;

    // Divider and shared multiplier.
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    div_result_t        div_res;
    logic [FrameW-1:0]  mul_a;
    logic [TexYW-1:0]   product;

    logic               cfg_write;

    assign opcode    = s_tuser;
    assign in_start  = s_tdata[9:0];
    assign in_stop   = s_tdata[19:10];
    assign in_enable = s_tdata[20];

    // ------------------------------------------------------------------
    // Configuration port. Writes land on the access cycle; pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_delay_reg    <= DelayW'(100);
            frames_per_row_reg <= PerRowW'(1);
            frame_width_reg    <= PixelW'(16);
            frame_height_reg   <= PixelW'(16);
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_FRAME_DELAY:    frame_delay_reg    <= pwdata[DelayW-1:0];
                REG_FRAMES_PER_ROW: frames_per_row_reg <= pwdata[PerRowW-1:0];
                REG_FRAME_WIDTH:    frame_width_reg    <= pwdata[PixelW-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= pwdata[PixelW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FRAME_DELAY:    prdata = {16'd0, frame_delay_reg};
            REG_FRAMES_PER_ROW: prdata = {24'd0, frames_per_row_reg};
            REG_FRAME_WIDTH:    prdata = {20'd0, frame_width_reg};
            REG_FRAME_HEIGHT:   prdata = {20'd0, frame_height_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame stepping. Counting down wraps to the top of the range once the
    // frame would fall below range_low; counting up wraps to the bottom once
    // it would pass range_high. Without looping the frame holds at the end of
    // the range, and a step never goes below zero or above the frame cap.
    // ------------------------------------------------------------------
    assign at_end     = down_reg ? (frame_reg == range_low_reg) : (frame_reg == range_high_reg);
    assign do_advance = (elapsed_reg >= frame_delay_reg) && (looping_reg || !at_end);

    always_comb begin
        if (down_reg) begin
            if (looping_reg && frame_reg <= range_low_reg) begin
                step_val = {1'b0, range_high_reg};
            end else if (frame_reg == '0) begin
                step_val = '0;
            end else begin
                step_val = {1'b0, frame_reg} - 1'b1;
            end
        end else begin
            if (looping_reg && frame_reg >= range_high_reg) begin
                step_val = {1'b0, range_low_reg};
            end else begin
                step_val = {1'b0, frame_reg} + 1'b1;
            end
        end
    end

    assign stepped    = (step_val > {1'b0, FrameCap}) ? FrameCap : step_val[FrameW-1:0];
    assign start_sat  = (in_start > FrameCap) ? FrameCap : in_start;
    assign draw_frame = do_advance ? stepped : frame_reg;
    assign wide_sheet = frames_per_row_reg > PerRowW'(1);
    assign same_range = (in_start == range_low_reg) && (in_stop == range_high_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg    <= '0;
            frame_reg      <= '0;
            range_low_reg  <= '0;
            range_high_reg <= '0;
            down_reg       <= 1'b0;
            looping_reg    <= 1'b1;
        end else if (accept) begin
            case (opcode)
                OP_TICK: begin
                    if (elapsed_reg != '1) begin
                        elapsed_reg <= elapsed_reg + 1'b1;
                    end
                end
                OP_DRAW: begin
                    if (do_advance) begin
                        elapsed_reg <= '0;
                        frame_reg   <= stepped;
                    end
                end
                OP_SET_LOOP: begin
                    looping_reg <= in_enable;
                    if (!same_range) begin
                        if (in_start <= in_stop) begin
                            range_low_reg  <= in_start;
                            range_high_reg <= in_stop;
                            down_reg       <= 1'b0;
                        end else begin
                            range_low_reg  <= in_stop;
                            range_high_reg <= in_start;
                            down_reg       <= 1'b1;
                        end
                        frame_reg <= start_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row and column: the divider splits the stepped frame by frames_per_row,
    // then the one multiplier scales the column and the row in turn.
    // ------------------------------------------------------------------
    assign div_start = accept && (opcode == OP_DRAW) && wide_sheet;

    sfs_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (draw_frame),
        .divisor  (frames_per_row_reg),
        .busy     (div_busy),
        .done     (div_done),
        .result   (div_res)
    );

    assign mul_a   = mul_row ? div_res.quotient : {2'b00, div_res.remainder};
    assign product = mul_a * (mul_row ? frame_height_reg : frame_width_reg);

    always_ff @(posedge aclk) begin
        if (accept && opcode == OP_DRAW) begin
            tex_x_reg <= '0;
            tex_y_reg <= '0;
            rect_reg  <= wide_sheet;
        end else if (state_reg == S_MUL_COL) begin
            tex_x_reg <= product[TexXW-1:0];
        end else if (state_reg == S_MUL_ROW) begin
            tex_y_reg <= product;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && opcode == OP_DRAW) begin
                    state_next = wide_sheet ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_MUL_COL;
                end
            end
            S_MUL_COL: state_next = S_MUL_ROW;
            S_MUL_ROW: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        mul_row  = 1'b0;
        case (state_reg)
            S_IDLE:    s_tready = 1'b1;
            S_DIV:     ;
            S_MUL_COL: ;
            S_MUL_ROW: mul_row = 1'b1;
            S_DONE:    load_out = !m_valid_reg || m_tready;
            default:   ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result until the sink takes it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {4'd0, tex_y_reg, tex_x_reg, frame_reg};
            m_rect_reg <= rect_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_rect_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The divider is never left running while the block takes new beats.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    // The current frame never exceeds the frame cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_reg <= FrameCap)
        else $error("current frame above cap");

    // A result without a recomputed rectangle carries a zero texture position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[51:10] == '0))
        else $error("texture position set on a narrow sheet");

    // A divide finishes into the multiply steps, never straight to the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_MUL_COL))
        else $error("sequencer skipped the multiply steps");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the sprite frame sequencer. Every beat taken on the input stream
// is replayed on a local animation model, and each draw leaves one expected result beat
// behind. Result beats are matched in order, field by field, against that store.
module testbench;
    import sfs_pkg::*;

    localparam int MAX_FRAMES    = 1024;
    // New frame values are clamped to the last frame, and never above the 10-bit field.
    localparam int FRAME_CAP     = (MAX_FRAMES - 1 > 1023) ? 1023 : MAX_FRAMES - 1;
    localparam int CYCLE_LIMIT   = 200_000;
    // Extra idle time after the last result, so that any work still in flight can finish.
    localparam int SETTLE_CYCLES = 40;
    // The one opcode that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [FrameW-1:0] frame_index;
        logic [TexXW-1:0]  texture_x;
        logic [TexYW-1:0]  texture_y;
        logic              rect_set;
    } draw_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // loop_start[9:0], loop_stop[19:10], loop_enable[20]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // frame_index[9:0], texture_x[29:10], texture_y[51:30]
    logic [0:0]  m_tuser;   // rect_set[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Sheet setup as the block should hold it.
    logic [DelayW-1:0]  cfg_delay;
    logic [PerRowW-1:0] cfg_per_row;
    logic [PixelW-1:0]  cfg_width;
    logic [PixelW-1:0]  cfg_height;

    // Animation state as the block should hold it.
    logic [DelayW-1:0] anim_elapsed;
    logic [FrameW-1:0] anim_frame;
    logic [FrameW-1:0] anim_low;
    logic [FrameW-1:0] anim_high;
    logic              anim_down;
    logic              anim_looping;

    draw_result_t pending_draws[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    bit           sender_gaps = 1'b1;
    bit           receiver_stalls = 1'b1;
    // Last set-loop range sent, so that random traffic can repeat it.
    logic [9:0]   prev_first = '0;
    logic [9:0]   prev_last = '0;

    sprite_frame_sequencer #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The run is cut off if it hangs anywhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [FrameW-1:0] clamp_frame(input int value);
        if (value < 0) begin
            return '0;
        end
        if (value > FRAME_CAP) begin
            return FrameW'(FRAME_CAP);
        end
        return FrameW'(value);
    endfunction

    // Applies one accepted beat to the animation state. A draw leaves its expected
    // result at the back of the store.
    task automatic apply_sprite_item(input logic [1:0] op, input logic [9:0] first,
                                     input logic [9:0] last, input logic wrap);
        int           next_frame;
        int           col;
        int           row;
        bit           at_end;
        draw_result_t want;
        case (op)
            OP_TICK: begin
                if (anim_elapsed != '1) begin
                    anim_elapsed = anim_elapsed + 1'b1;
                end
            end
            OP_SET_LOOP: begin
                anim_looping = wrap;
                // The same stored range only changes the loop flag.
                if (!(first == anim_low && last == anim_high)) begin
                    if (first <= last) begin
                        anim_low  = first;
                        anim_high = last;
                        anim_down = 1'b0;
                    end else begin
                        anim_low  = last;
                        anim_high = first;
                        anim_down = 1'b1;
                    end
                    anim_frame = clamp_frame(int'(first));
                end
            end
            OP_DRAW: begin
                at_end = anim_down ? (anim_frame == anim_low) : (anim_frame == anim_high);
                if (anim_elapsed >= cfg_delay && (anim_looping || !at_end)) begin
                    anim_elapsed = '0;
                    if (anim_down) begin
                        next_frame = int'(anim_frame) - 1;
                        if (anim_looping && next_frame < int'(anim_low)) begin
                            next_frame = int'(anim_high);
                        end
                    end else begin
                        next_frame = int'(anim_frame) + 1;
                        if (anim_looping && next_frame > int'(anim_high)) begin
                            next_frame = int'(anim_low);
                        end
                    end
                    anim_frame = clamp_frame(next_frame);
                end
                want.frame_index = anim_frame;
                if (cfg_per_row > 1) begin
                    col = int'(anim_frame) % int'(cfg_per_row);
                    row = int'(anim_frame) / int'(cfg_per_row);
                    want.texture_x = TexXW'(col * int'(cfg_width));
                    want.texture_y = TexYW'(row * int'(cfg_height));
                    want.rect_set  = 1'b1;
                end else begin
                    want.texture_x = '0;
                    want.texture_y = '0;
                    want.rect_set  = 1'b0;
                end
                pending_draws.push_back(want);
            end
            default: begin
            end
        endcase
    endtask

    // Input side: every beat taken by the block goes through the model.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_sprite_item(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[20]);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: each result beat is matched against the oldest pending draw.
    always @(posedge aclk) begin
        draw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: result beat with no draw pending, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_draws.pop_front();
                check_field("frame_index", 32'(want.frame_index), 32'(m_tdata[9:0]));
                check_field("texture_x", 32'(want.texture_x), 32'(m_tdata[29:10]));
                check_field("texture_y", 32'(want.texture_y), 32'(m_tdata[51:30]));
                check_field("rect_set", 32'(want.rect_set), 32'(m_tuser[0]));
            end
        end
    end

    // The result sink stalls in short random bursts unless told to keep up.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offers one beat and returns at the edge that takes it. tvalid stays high on return,
    // so back-to-back beats go out without a bubble unless a random gap is drawn.
    task automatic send_beat(input logic [1:0] op, input logic [9:0] first,
                             input logic [9:0] last, input logic wrap);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, wrap, last, first};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits for every pending draw, then lets the block settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] held;
        case (idx)
            REG_FRAME_DELAY: begin
                cfg_delay = value[DelayW-1:0];
                held = 32'(cfg_delay);
            end
            REG_FRAMES_PER_ROW: begin
                cfg_per_row = value[PerRowW-1:0];
                held = 32'(cfg_per_row);
            end
            REG_FRAME_WIDTH: begin
                cfg_width = value[PixelW-1:0];
                held = 32'(cfg_width);
            end
            default: begin
                cfg_height = value[PixelW-1:0];
                held = 32'(cfg_height);
            end
        endcase
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== held) begin
            $display("%0t: register %0d read back mismatch, expected %0d, actual %0d",
                     $time, idx, held, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_sheet_setup(input int delay, input int per_row, input int width,
                                    input int height);
        program_register(REG_FRAME_DELAY, 32'(delay));
        program_register(REG_FRAMES_PER_ROW, 32'(per_row));
        program_register(REG_FRAME_WIDTH, 32'(width));
        program_register(REG_FRAME_HEIGHT, 32'(height));
    endtask

    task automatic test_directed_cases();
        // Reset setup: a long delay and one frame per row, so no step and no rectangle.
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        send_beat(OP_UNUSED, 10'h3FF, 10'h3FF, 1'b1);
        send_beat(OP_TICK, 10'd0, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        wait_for_results();
        load_sheet_setup(0, 4, 4095, 4095);
        // Reversed range without looping: counts down from the top frame.
        send_beat(OP_SET_LOOP, 10'd1023, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        // Repeating a reversed set-loop reloads the frame, since the range is stored
        // swapped. Sending it swapped matches the stored range and only sets the flag.
        send_beat(OP_SET_LOOP, 10'd1023, 10'd0, 1'b1);
        send_beat(OP_SET_LOOP, 10'd0, 10'd1023, 1'b1);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        // Small looping range counting up wraps from the high end to the low end.
        send_beat(OP_SET_LOOP, 10'd5, 10'd7, 1'b1);
        repeat (4) send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        // Same range, looping off: the frame holds once it reaches the end.
        send_beat(OP_SET_LOOP, 10'd5, 10'd7, 1'b0);
        repeat (3) send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        // Counting down with looping wraps from the low end to the high end.
        send_beat(OP_SET_LOOP, 10'd7, 10'd5, 1'b1);
        repeat (3) send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        wait_for_results();
        load_sheet_setup(65535, 255, 0, 4095);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        wait_for_results();
        // No frames per row at all gives no rectangle either.
        load_sheet_setup(0, 0, 4095, 0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        wait_for_results();
    endtask

    // A draw steps the frame only once the elapsed count has reached the delay, and
    // the count starts again from zero after each step.
    task automatic test_delay_threshold();
        sender_gaps = 1'b0;
        load_sheet_setup(40, 8, 100, 200);
        send_beat(OP_SET_LOOP, 10'd16, 10'd23, 1'b1);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        repeat (39) send_beat(OP_TICK, 10'd0, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        send_beat(OP_TICK, 10'd0, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        send_beat(OP_DRAW, 10'd0, 10'd0, 1'b0);
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    // Random mix of beats. Half the set-loops name short ranges so that frames step,
    // wrap and hold often, and some repeat the previous range to hit the unchanged case.
    task automatic test_random_traffic(input int beats);
        int         sent;
        int         pick;
        logic [9:0] base;
        logic [9:0] first;
        logic [9:0] last;
        logic [1:0] op;
        sent = 0;
        while (sent < beats) begin
            pick  = $urandom_range(0, 99);
            first = 10'($urandom);
            last  = 10'($urandom);
            op = (pick < 38) ? OP_TICK : (pick < 78) ? OP_DRAW :
                 (pick < 95) ? OP_SET_LOOP : OP_UNUSED;
            if (op == OP_SET_LOOP) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        base  = 10'($urandom_range(0, 1015));
                        first = 10'(base + $urandom_range(0, 8));
                        last  = 10'(base + $urandom_range(0, 8));
                    end
                    5, 6: begin
                    end
                    7: begin
                        first = prev_first;
                        last  = prev_last;
                    end
                    default: begin
                        // A reversed range is stored swapped, so send it that way.
                        first = (prev_first > prev_last) ? prev_last : prev_first;
                        last  = (prev_first > prev_last) ? prev_first : prev_last;
                    end
                endcase
                prev_first = first;
                prev_last  = last;
            end
            send_beat(op, first, last, 1'($urandom_range(0, 1)));
            sent++;
        end
        wait_for_results();
    endtask

    // Several sheet setups, each followed by a full drain before the next write.
    task automatic test_random_sheets();
        load_sheet_setup(1, 3, $urandom_range(0, 4095), $urandom_range(0, 4095));
        test_random_traffic(240);
        load_sheet_setup(0, 255, 4095, 4095);
        test_random_traffic(240);
        load_sheet_setup(2, 0, 0, 0);
        test_random_traffic(240);
        load_sheet_setup(4, $urandom_range(2, 254), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
        test_random_traffic(240);
        load_sheet_setup(1, 1, $urandom_range(0, 4095), $urandom_range(0, 4095));
        test_random_traffic(240);
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_steady_stream();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        load_sheet_setup($urandom_range(0, 3), 2, 4095, 4095);
        test_random_traffic(240);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        // Register and animation state right after reset.
        cfg_delay    = 16'd100;
        cfg_per_row  = 8'd1;
        cfg_width    = 12'd16;
        cfg_height   = 12'd16;
        anim_elapsed = '0;
        anim_frame   = '0;
        anim_low     = '0;
        anim_high    = '0;
        anim_down    = 1'b0;
        anim_looping = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_delay_threshold();
        test_random_sheets();
        test_steady_stream();

        if (mismatch_count == 0 && pending_draws.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
